>>> design/esw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esw_pkg;

  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned NUM_W       = 6;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned ENTRY_W     = NUM_W + WEIGHT_W + VALUE_W;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - ENTRY_W;

  // number sits in the low bits so the entry maps straight onto tdata
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [WEIGHT_W-1:0] weight;
    logic [NUM_W-1:0]    number;
  } entry_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_LOADCUR,
    S_SCAN,
    S_WB,
    S_ERD,
    S_EWR
  } state_e;

  typedef struct packed {
    logic load_wr;
    logic wb_en;
    logic rd_en;
    logic cur_load;
    logic cmp_en;
    logic out_load;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

>>> design/esw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module esw_datapath #(
  parameter int unsigned AW = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire esw_pkg::cmd_t                 cmd_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire logic [AW-1:0]                 rd_addr_i,
  input  wire logic [esw_pkg::NUM_W-1:0]     load_num_i,
  input  wire logic [esw_pkg::WEIGHT_W-1:0]  in_weight_i,
  input  wire logic [esw_pkg::VALUE_W-1:0]   in_value_i,
  input  wire logic                          m_tready_i,
  output esw_pkg::sts_t                      sts_o,
  output logic                               m_valid_o,
  output esw_pkg::entry_t                    m_entry_o,
  output logic                               m_last_o
);

  localparam int unsigned DEPTH = 1 << AW;

  esw_pkg::entry_t mem [DEPTH];

  esw_pkg::entry_t rd_data_q;
  logic [AW-1:0]   rd_addr_q;
  esw_pkg::entry_t cur_q, cur_d;
  logic            swap;
  logic            we;
  logic [AW-1:0]   waddr;
  esw_pkg::entry_t wdata;

  logic            m_valid_q, m_valid_d;
  esw_pkg::entry_t m_entry_q;
  logic            m_last_q;

  // held entry beats the scanned one: swap them
  assign swap = cmd_i.cmp_en && (cur_q.weight > rd_data_q.weight);

  always_comb begin
    we    = 1'b0;
    waddr = wr_addr_i;
    wdata = cur_q;
    if (cmd_i.load_wr) begin
      we           = 1'b1;
      wdata.number = load_num_i;
      wdata.weight = in_weight_i;
      wdata.value  = in_value_i;
    end else if (cmd_i.wb_en) begin
      we = 1'b1;
    end else if (swap) begin
      we    = 1'b1;
      waddr = rd_addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  always_comb begin
    cur_d = cur_q;
    if (cmd_i.cur_load || swap) begin
      cur_d = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_i.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_entry_q <= rd_data_q;
      m_last_q  <= cmd_i.out_last;
    end
  end

  assign sts_o.out_busy = m_valid_q && !m_tready_i;
  assign m_valid_o      = m_valid_q;
  assign m_entry_o      = m_entry_q;
  assign m_last_o       = m_last_q;

`ifndef SYNTHESIS
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && cmd_i.rd_en) |-> (waddr != rd_addr_i))
    else $error("store read and write hit the same entry");

  a_no_out_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(m_valid_q && !m_tready_i))
    else $error("output word overwritten while waiting");

  a_cmp_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmp_en |-> $past(cmd_i.rd_en))
    else $error("compare without fresh read data");

  a_load_not_in_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_wr |-> !(cmd_i.cmp_en || cmd_i.cur_load || cmd_i.wb_en))
    else $error("input write during sort");
`endif

endmodule

`default_nettype wire

>>> design/esw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module esw_ctrl #(
  parameter int unsigned MAX_ITEMS = 32,
  parameter int unsigned AW        = 5,
  parameter int unsigned CW        = 6
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_valid_i,
  input  wire logic                      s_last_i,
  output logic                           s_ready_o,
  input  wire esw_pkg::sts_t             sts_i,
  output esw_pkg::cmd_t                  cmd_o,
  output logic [AW-1:0]                  wr_addr_o,
  output logic [AW-1:0]                  rd_addr_o,
  output logic [esw_pkg::NUM_W-1:0]      load_num_o
);

  esw_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   i_q, i_d;
  logic [CW-1:0]   j_q, j_d;
  logic [CW-1:0]   cnt_nx;
  logic [CW-1:0]   i_nx;
  logic            accept;
  logic            load_end;

  assign cnt_nx   = cnt_q + CW'(1);
  assign i_nx     = i_q + CW'(1);
  assign accept   = (state_q == esw_pkg::S_LOAD) && s_valid_i;
  assign load_end = s_last_i || (cnt_nx == CW'(MAX_ITEMS));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    unique case (state_q)
      esw_pkg::S_LOAD: begin
        if (accept) begin
          cnt_d = cnt_nx;
          i_d   = '0;
          j_d   = CW'(1);
          if (load_end) begin
            state_d = (cnt_nx > CW'(1)) ? esw_pkg::S_LOADCUR : esw_pkg::S_ERD;
          end
        end
      end
      esw_pkg::S_LOADCUR: begin
        j_d     = j_q + CW'(1);
        state_d = esw_pkg::S_SCAN;
      end
      esw_pkg::S_SCAN: begin
        if (j_q < cnt_q) begin
          j_d = j_q + CW'(1);
        end else begin
          state_d = esw_pkg::S_WB;
        end
      end
      esw_pkg::S_WB: begin
        if ((i_nx + CW'(1)) < cnt_q) begin
          i_d     = i_nx;
          j_d     = i_nx + CW'(1);
          state_d = esw_pkg::S_LOADCUR;
        end else begin
          i_d     = '0;
          state_d = esw_pkg::S_ERD;
        end
      end
      esw_pkg::S_ERD: begin
        state_d = esw_pkg::S_EWR;
      end
      esw_pkg::S_EWR: begin
        if (!sts_i.out_busy) begin
          i_d = i_nx;
          if (i_nx == cnt_q) begin
            cnt_d   = '0;
            state_d = esw_pkg::S_LOAD;
          end else begin
            state_d = esw_pkg::S_ERD;
          end
        end
      end
      default: state_d = esw_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esw_pkg::S_LOAD;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    s_ready_o  = 1'b0;
    wr_addr_o  = cnt_q[AW-1:0];
    rd_addr_o  = j_q[AW-1:0];
    load_num_o = esw_pkg::NUM_W'(cnt_nx);
    unique case (state_q)
      esw_pkg::S_LOAD: begin
        s_ready_o     = 1'b1;
        cmd_o.load_wr = accept;
        // first pass head is fetched while the closing word is written
        cmd_o.rd_en   = accept && load_end && (cnt_nx > CW'(1));
        rd_addr_o     = '0;
      end
      esw_pkg::S_LOADCUR: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.rd_en    = 1'b1;
      end
      esw_pkg::S_SCAN: begin
        cmd_o.cmp_en = 1'b1;
        cmd_o.rd_en  = (j_q < cnt_q);
      end
      esw_pkg::S_WB: begin
        cmd_o.wb_en = 1'b1;
        wr_addr_o   = i_q[AW-1:0];
        rd_addr_o   = i_nx[AW-1:0];
        cmd_o.rd_en = ((i_nx + CW'(1)) < cnt_q);
      end
      esw_pkg::S_ERD: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = i_q[AW-1:0];
      end
      esw_pkg::S_EWR: begin
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.out_last = (i_nx == cnt_q);
      end
      default: cmd_o = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS))
    else $error("load count past store depth");

  a_sort_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != esw_pkg::S_LOAD) |-> (cnt_q != '0))
    else $error("sort or emit with empty list");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == esw_pkg::S_SCAN) |-> (j_q > i_q))
    else $error("scan index not past head");
`endif

endmodule

`default_nettype wire

>>> design/exchange_sort_by_weight_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata (low bit up)                          tlast
// s_axis    in   weight[15:0], item_value[31:16]              last
// m_axis    out  item_number[5:0], sorted_weight[21:6],       end_of_list
//                sorted_value[37:22], zero pad[39:38]
//
// Load: one word per cycle. Sort: one compare per cycle while scanning, against
// a held entry through one read and one write port of the store. Emit: each word
// is read from the store, then loaded into the output register once the sink is free.
// Reset clears the controller and the output valid; the store is not cleared.
// A stalled sink holds emission; the last result may wait while a new load runs.

module exchange_sort_by_weight_core #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [esw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // weight, item_value
  input  wire logic                               s_axis_tlast,  // last
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [esw_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // item_number,
                                                                 // sorted_weight,
                                                                 // sorted_value
  output logic                                    m_axis_tlast   // end_of_list
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  esw_pkg::cmd_t                 cmd;
  esw_pkg::sts_t                 sts;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;
  logic [esw_pkg::NUM_W-1:0]     load_num;
  esw_pkg::entry_t               m_entry;

  esw_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_last_i   (s_axis_tlast),
    .s_ready_o  (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .load_num_o (load_num)
  );

  esw_datapath #(
    .AW (AW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .wr_addr_i   (wr_addr),
    .rd_addr_i   (rd_addr),
    .load_num_i  (load_num),
    .in_weight_i (s_axis_tdata[esw_pkg::WEIGHT_W-1:0]),
    .in_value_i  (s_axis_tdata[esw_pkg::WEIGHT_W +: esw_pkg::VALUE_W]),
    .m_tready_i  (m_axis_tready),
    .sts_o       (sts),
    .m_valid_o   (m_axis_tvalid),
    .m_entry_o   (m_entry),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {{esw_pkg::OUT_PAD_W{1'b0}}, m_entry};

endmodule

`default_nettype wire
